>>> src/vertex_weld_dedup_assert.svh
// ----------------------------------------------------------------
// vertex weld dedup assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------
`ifndef VERTEX_WELD_DEDUP_ASSERT_SVH
`define VERTEX_WELD_DEDUP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define VWD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/vwd_pkg.sv
// ----------------------------------------------------------------
// vwd_pkg
// request and response types, codes and control structs
// ----------------------------------------------------------------
package vwd_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_REMAP = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic REG_WORDS_PER_VERTEX = 1'b0;

	typedef struct packed {
		op_t         operation;
		logic [31:0] data_word;
		logic        word_last;
		logic [11:0] vertex_index;
		logic [4:0]  word_index;
	} req_t;

	typedef struct packed {
		logic [11:0] welded_index;
		logic        is_new;
		logic [12:0] unique_count;
		logic [31:0] read_word;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic load_word;
		logic cmp_issue;
		logic cmp_check;
		logic copy_step;
		logic remap_issue;
		logic read_issue;
		logic clear;
		logic set_full;
		logic set_range;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic load_done;
		logic full;
		logic remap_ok;
		logic read_ok;
		logic k_done;
		logic word_eq;
		logic i_last;
		logic copy_last;
	} sts_t;

endpackage

>>> src/vwd_ctrl.sv
// ----------------------------------------------------------------
// vwd_ctrl
// sequencer for load, compare, append, remap, read, clear and response handoff
// ----------------------------------------------------------------
module vwd_ctrl
	import vwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  op_t  op,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_CHECK,
		S_COPY,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign accept    = req_valid && (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_LOAD: begin
							cmd.load_word = 1'b1;
							cmd.set_full  = sts.load_done && sts.full;
						end
						OP_REMAP: begin
							cmd.remap_issue = sts.remap_ok;
							cmd.set_range   = !sts.remap_ok;
						end
						OP_READ: begin
							cmd.read_issue = sts.read_ok;
							cmd.set_range  = !sts.read_ok;
						end
						OP_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			S_ISSUE: cmd.cmp_issue = !sts.k_done;
			S_CHECK: cmd.cmp_check = 1'b1;
			S_COPY:  cmd.copy_step = 1'b1;
			S_EMIT:  cmd.out_load  = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_LOAD) begin
							if (sts.load_done) begin
								state_q <= sts.full ? S_EMIT : S_ISSUE;
							end
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_ISSUE: state_q <= sts.k_done ? S_COPY : S_CHECK;
				S_CHECK: state_q <= (sts.word_eq && sts.i_last) ? S_EMIT : S_ISSUE;
				S_COPY: begin
					if (sts.copy_last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/vwd_datapath.sv
// ----------------------------------------------------------------
// vwd_datapath
// incoming buffer, unique store, remap table and counters
// ----------------------------------------------------------------
module vwd_datapath
	import vwd_pkg::*;
#(
	parameter int MAX_VERTICES = 4096,
	parameter int MAX_WORDS    = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  req_t       req,
	input  logic [5:0] wpv,
	output sts_t       sts,
	output rsp_t       rsp_data
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int WPW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WCW = $clog2(MAX_WORDS + 1);
	localparam int AW  = $clog2(MAX_VERTICES * MAX_WORDS);

	typedef enum logic [1:0] {
		SEL_REG,
		SEL_MAP,
		SEL_STORE
	} sel_t;

	logic [31:0]    vtx_q [MAX_WORDS];
	logic [31:0]    store_mem [MAX_VERTICES * MAX_WORDS];
	logic [VW-1:0]  map_mem [MAX_VERTICES];
	logic [31:0]    store_rdata_q;
	logic [VW-1:0]  map_rdata_q;

	logic [WPW-1:0] pos_q;
	logic [WPW-1:0] last_pos_q;
	logic [WPW-1:0] i_q;
	logic [CW-1:0]  loaded_q;
	logic [CW-1:0]  stored_q;
	logic [CW-1:0]  k_q;
	logic [AW-1:0]  base_q;

	logic [11:0]    res_welded_q;
	logic           res_new_q;
	logic [1:0]     res_status_q;
	sel_t           res_sel_q;
	rsp_t           rsp_q;

	logic [WCW-1:0] eff;
	logic [31:0]    cur_word;
	logic [AW-1:0]  st_raddr;
	logic           match;
	logic           append;

	// clamp of the word count register
	always_comb begin
		if (wpv == 6'd0) begin
			eff = WCW'(1);
		end else if (32'(wpv) > MAX_WORDS) begin
			eff = WCW'(MAX_WORDS);
		end else begin
			eff = WCW'(wpv);
		end
	end

	// positions past the last loaded word count as zero
	assign cur_word = (i_q <= last_pos_q) ? vtx_q[i_q] : 32'd0;

	assign sts.load_done = req.word_last ||
		((WCW + 1)'(pos_q) + (WCW + 1)'(1) >= (WCW + 1)'(eff));
	assign sts.full      = (32'(loaded_q) >= MAX_VERTICES);
	assign sts.remap_ok  = (32'(req.vertex_index) < 32'(loaded_q));
	assign sts.read_ok   = (32'(req.vertex_index) < 32'(stored_q)) &&
		(32'(req.word_index) < 32'(eff));
	assign sts.k_done    = (k_q == stored_q);
	assign sts.word_eq   = (store_rdata_q == cur_word);
	assign sts.i_last    = ((WCW + 1)'(i_q) + (WCW + 1)'(1) == (WCW + 1)'(eff));
	assign sts.copy_last = (32'(i_q) == MAX_WORDS - 1);

	assign match  = cmd.cmp_check && sts.word_eq && sts.i_last;
	assign append = cmd.copy_step && sts.copy_last;

	assign st_raddr = cmd.cmp_issue ? (base_q + AW'(i_q)) :
		AW'(32'(req.vertex_index) * MAX_WORDS + 32'(req.word_index));

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			vtx_q[pos_q] <= req.data_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_step) begin
			store_mem[base_q + AW'(i_q)] <= cur_word;
		end
		if (cmd.cmp_issue || cmd.read_issue) begin
			store_rdata_q <= store_mem[st_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			map_mem[loaded_q[VW-1:0]] <= k_q[VW-1:0];
		end else if (append) begin
			map_mem[loaded_q[VW-1:0]] <= stored_q[VW-1:0];
		end
		if (cmd.remap_issue) begin
			map_rdata_q <= map_mem[VW'(req.vertex_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			last_pos_q <= '0;
			i_q        <= '0;
			k_q        <= '0;
			base_q     <= '0;
			loaded_q   <= '0;
			stored_q   <= '0;
		end else begin
			if (cmd.load_word) begin
				if (sts.load_done) begin
					last_pos_q <= pos_q;
					pos_q      <= '0;
					i_q        <= '0;
					k_q        <= '0;
					base_q     <= '0;
				end else begin
					pos_q <= pos_q + WPW'(1);
				end
			end
			if (cmd.cmp_check) begin
				if (sts.word_eq) begin
					if (sts.i_last) begin
						loaded_q <= loaded_q + CW'(1);
					end else begin
						i_q <= i_q + WPW'(1);
					end
				end else begin
					k_q    <= k_q + CW'(1);
					base_q <= base_q + AW'(MAX_WORDS);
					i_q    <= '0;
				end
			end
			if (cmd.copy_step) begin
				i_q <= i_q + WPW'(1);
				if (sts.copy_last) begin
					loaded_q <= loaded_q + CW'(1);
					stored_q <= stored_q + CW'(1);
				end
			end
			if (cmd.clear) begin
				pos_q    <= '0;
				loaded_q <= '0;
				stored_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_full || cmd.set_range || cmd.clear) begin
			res_welded_q <= '0;
			res_new_q    <= 1'b0;
			res_status_q <= cmd.set_full ? ST_FULL : (cmd.set_range ? ST_RANGE : ST_OK);
			res_sel_q    <= SEL_REG;
		end else if (match) begin
			res_welded_q <= 12'(k_q);
			res_new_q    <= 1'b0;
			res_status_q <= ST_OK;
			res_sel_q    <= SEL_REG;
		end else if (append) begin
			res_welded_q <= 12'(stored_q);
			res_new_q    <= 1'b1;
			res_status_q <= ST_OK;
			res_sel_q    <= SEL_REG;
		end else if (cmd.remap_issue || cmd.read_issue) begin
			res_welded_q <= '0;
			res_new_q    <= 1'b0;
			res_status_q <= ST_OK;
			res_sel_q    <= cmd.remap_issue ? SEL_MAP : SEL_STORE;
		end
		if (cmd.out_load) begin
			rsp_q.welded_index <= (res_sel_q == SEL_MAP) ? 12'(map_rdata_q) : res_welded_q;
			rsp_q.is_new       <= res_new_q;
			rsp_q.unique_count <= 13'(stored_q);
			rsp_q.read_word    <= (res_sel_q == SEL_STORE) ? store_rdata_q : 32'd0;
			rsp_q.status       <= res_status_q;
		end
	end

	assign rsp_data = rsp_q;

endmodule

>>> src/vertex_weld_dedup.sv
// ----------------------------------------------------------------
// vertex_weld_dedup
// non-final load word: stored while the sequencer stays idle; remap, read, clear, full store: straight to response
// completed vertex: issue and check per word compared, scan over stored vertices, MAX_WORDS-word copy on append
// compares read one stored word at a time through the single store read port
// reset clears counters and sets words_per_vertex to 1; memories are not cleared
// ----------------------------------------------------------------
module vertex_weld_dedup
	import vwd_pkg::*;
#(
	parameter int MAX_VERTICES = 4096,
	parameter int MAX_WORDS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req_data,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp_data,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0] wpv_q;
	cmd_t       cmd;
	sts_t       sts;

	// single register, always ready
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WORDS_PER_VERTEX) ? {26'd0, wpv_q} : 32'd0;

	// writes land only in the access phase; other addresses are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpv_q <= 6'd1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_WORDS_PER_VERTEX)) begin
			wpv_q <= pwdata[5:0];
		end
	end

	// sequencer: accepts only when idle, holds the response register valid
	vwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.op        (req_data.operation),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage, counters, compare and response payload
	vwd_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_WORDS    (MAX_WORDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req_data),
		.wpv      (wpv_q),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

endmodule

>>> src/vwd_checker.sv
// ----------------------------------------------------------------
// vwd_checker
// port-level checks on the response channel
// ----------------------------------------------------------------
`include "vertex_weld_dedup_assert.svh"

module vwd_checker
	import vwd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_data
);

	`VWD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
	`VWD_ASSERT_NOW(a_full_clean, rsp_valid && (rsp_data.status == ST_FULL), (rsp_data.welded_index == 12'd0) && !rsp_data.is_new, "full response carries an index")
	`VWD_ASSERT_NOW(a_new_count, rsp_valid && rsp_data.is_new, (rsp_data.status == ST_OK) && (rsp_data.read_word == 32'd0) && (rsp_data.unique_count[11:0] == 12'(rsp_data.welded_index + 12'd1)), "appended vertex index does not match count")

endmodule

bind vertex_weld_dedup vwd_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
